### rtl/core/ppts_pkg.sv
package ppts_pkg;

  // field widths
  localparam int ENT_W   = 16;  // Q5.10 matrix entry
  localparam int PT_W    = 33;  // Q16.16 point, one guard bit for pos+dir
  localparam int PROD_W  = 49;  // entry times point
  localparam int CLIP_W  = 50;  // clip coordinate, 26 fraction bits
  localparam int MAG_W   = 50;  // clip magnitude
  localparam int FRAC_SH = 16;  // fraction bits of the quotient
  localparam int Q_W     = 41;  // quotient bits, one divider step each
  localparam int OVF_SH  = Q_W - FRAC_SH;
  localparam int NDC_W   = 42;  // signed normalised value, up to 2^40
  localparam int SCR_W   = 60;  // doubled screen value and its products

  localparam logic [Q_W-1:0] NDC_LIMIT = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [NDC_W:0] ONE_Q16   = (NDC_W+1)'(65536);

  localparam logic signed [SCR_W-1:0] S32_MAX = SCR_W'(64'sh7fff_ffff);
  localparam logic signed [SCR_W-1:0] S32_MIN = ~S32_MAX;

  // register indexes
  localparam logic [2:0] REG_ROW0     = 3'd0;
  localparam logic [2:0] REG_ROW1     = 3'd1;
  localparam logic [2:0] REG_ROW2     = 3'd2;
  localparam logic [2:0] REG_ROW3     = 3'd3;
  localparam logic [2:0] REG_VIEWPORT = 3'd4;

  // register reset values: identity matrix, 640 by 480 viewport
  localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_0400;
  localparam logic [63:0] ROW1_RST = 64'h0000_0000_0400_0000;
  localparam logic [63:0] ROW2_RST = 64'h0000_0400_0000_0000;
  localparam logic [63:0] ROW3_RST = 64'h0400_0000_0000_0000;
  localparam logic [63:0] VP_RST   = 64'h01e0_0280_0000_0000;

  // function codes
  localparam logic [1:0] FUNC_SCREEN = 2'd0;
  localparam logic [1:0] FUNC_DELTA  = 2'd1;
  localparam logic [1:0] FUNC_NDC    = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] func;
    logic       fault;
  } side_t;

  function automatic logic [MAG_W-1:0] mag_abs(input logic signed [CLIP_W-1:0] v);
    logic signed [CLIP_W-1:0] n;
    n = -v;
    return v[CLIP_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  function automatic logic signed [NDC_W-1:0] ndc_from_quo(input logic [Q_W-1:0] quo,
                                                          input logic ovf,
                                                          input logic neg);
    logic [Q_W-1:0] mag;
    logic signed [NDC_W-1:0] m;
    mag = (ovf || (quo > NDC_LIMIT)) ? NDC_LIMIT : quo;
    m   = $signed(NDC_W'(mag));
    return neg ? -m : m;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SCR_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

### rtl/core/ppts_xform.sv
module ppts_xform
  import ppts_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [PT_W-1:0]   pt_x_i,
  input  logic signed [PT_W-1:0]   pt_y_i,
  input  logic signed [PT_W-1:0]   pt_z_i,
  input  logic [3:0][63:0]         rows_i,
  output logic signed [CLIP_W-1:0] clip_o [4]
);

  logic signed [PT_W-1:0]   pt [3];
  logic signed [PROD_W-1:0] prod_q [4][3];
  logic signed [CLIP_W-1:0] clip_d [4];
  logic signed [CLIP_W-1:0] clip_q [4];

  assign pt[0] = pt_x_i;
  assign pt[1] = pt_y_i;
  assign pt[2] = pt_z_i;

  // stage 1: twelve entry by coordinate products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= PROD_W'($signed(rows_i[r][ENT_W*c +: ENT_W])) * PROD_W'(pt[c]);
        end
      end
    end
  end

  // stage 2: row sums plus the w column scaled by one
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip_d[r] = CLIP_W'(prod_q[r][0]) + CLIP_W'(prod_q[r][1]) + CLIP_W'(prod_q[r][2])
                + $signed({{(CLIP_W-ENT_W-16){rows_i[r][4*ENT_W-1]}},
                           rows_i[r][3*ENT_W +: ENT_W], 16'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clip_q <= clip_d;
    end
  end

  assign clip_o = clip_q;

endmodule

### rtl/core/ppts_div.sv
module ppts_div
  import ppts_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] num_i,
  input  logic [MAG_W-1:0] den_i,
  input  logic             neg_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             ovf_o,
  output logic             neg_o
);

  logic [MAG_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [MAG_W-1:0] den_q [Q_W];
  logic             ovf_q [Q_W];
  logic             neg_q [Q_W];

  // one restoring step per stage, dividend is num shifted up by the fraction
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [MAG_W-1:0] rem_s;
    logic [Q_W-1:0]   low_s;
    logic [Q_W-1:0]   quo_s;
    logic [MAG_W-1:0] den_s;
    logic             ovf_s;
    logic             neg_s;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      // quotient would need more than Q_W bits when the top of num reaches den
      assign rem_s = {{OVF_SH{1'b0}}, num_i[MAG_W-1:OVF_SH]};
      assign low_s = {num_i[OVF_SH-1:0], {FRAC_SH{1'b0}}};
      assign quo_s = '0;
      assign den_s = den_i;
      assign ovf_s = ({{OVF_SH{1'b0}}, num_i[MAG_W-1:OVF_SH]} >= den_i);
      assign neg_s = neg_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign low_s = low_q[k-1];
      assign quo_s = quo_q[k-1];
      assign den_s = den_q[k-1];
      assign ovf_s = ovf_q[k-1];
      assign neg_s = neg_q[k-1];
    end

    assign trial = {rem_s, low_s[Q_W-1]};
    assign ge    = (trial >= {1'b0, den_s});
    assign diff  = trial - {1'b0, den_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        low_q[k] <= {low_s[Q_W-2:0], 1'b0};
        quo_q[k] <= {quo_s[Q_W-2:0], ge};
        den_q[k] <= den_s;
        ovf_q[k] <= ovf_s;
        neg_q[k] <= neg_s;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];
  assign ovf_o = ovf_q[Q_W-1];
  assign neg_o = neg_q[Q_W-1];

endmodule

### rtl/core/ppts_vport.sv
module ppts_vport
  import ppts_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [Q_W-1:0]          quo_i,
  input  logic                    ovf_i,
  input  logic                    neg_i,
  input  logic [15:0]             org_i,
  input  logic [15:0]             len_i,
  output logic signed [NDC_W-1:0] ndc_o,
  output logic signed [SCR_W-1:0] scr_o
);

  logic signed [NDC_W-1:0] ndc_a_q, ndc_b_q, ndc_c_q;
  logic signed [NDC_W:0]   shifted;
  logic signed [SCR_W-1:0] prod_q;
  logic signed [SCR_W-1:0] s2;
  logic signed [SCR_W-1:0] scr_q;

  assign shifted = $signed({ndc_a_q[NDC_W-1], ndc_a_q}) + $signed(ONE_Q16);
  assign s2      = prod_q + $signed(SCR_W'({org_i, 17'b0}));

  // clamp and sign, then add one and scale by size, then add the doubled origin and halve
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ndc_a_q <= ndc_from_quo(quo_i, ovf_i, neg_i);
      prod_q  <= SCR_W'(shifted) * $signed(SCR_W'({1'b0, len_i}));
      ndc_b_q <= ndc_a_q;
      scr_q   <= s2 >>> 1;
      ndc_c_q <= ndc_b_q;
    end
  end

  assign ndc_o = ndc_c_q;
  assign scr_o = scr_q;

endmodule

### rtl/core/perspective_project_to_screen.sv
// Perspective projection with viewport mapping.
// Input channel: in_valid_i / in_stall_o carry one beat per point with func_i,
// pos_*_i and dir_*_i. Output channel: out_valid_o / out_stall_i carry one
// beat per input beat with out_x_o, out_y_o, out_z_o and div_fault_o.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (rows 0
// to 3 of the matrix, then the viewport); indexes above 4 are ignored. Write
// only while no beat is in flight.
// Throughput is one beat per cycle while the output is not stalled. A beat
// passes an input stage, two matrix stages, a divide set-up stage, a
// 41-stage restoring divider (one quotient bit per stage) and four stages for
// clamp, viewport scale, origin add and the output register.
// Reset empties the pipeline and loads the identity matrix and a 640 by 480
// viewport at origin 0, 0. When the receiver stalls a valid output beat, the
// whole pipeline holds and in_stall_o is raised in the same cycle; nothing is
// dropped or repeated.
module perspective_project_to_screen
  import ppts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               div_fault_o
);

  localparam int SIDE_N = Q_W + 4;
  localparam int NDIV   = 5;

  logic [3:0][63:0] row_q;
  logic [63:0]      vp_q;
  logic             adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      row_q[3] <= ROW3_RST;
      vp_q     <= VP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW0:     row_q[0] <= cfg_wdata_i;
        REG_ROW1:     row_q[1] <= cfg_wdata_i;
        REG_ROW2:     row_q[2] <= cfg_wdata_i;
        REG_ROW3:     row_q[3] <= cfg_wdata_i;
        REG_VIEWPORT: vp_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished beat is held at the output
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // input stage, pos+dir formed exactly
  side_t s0_sd_q, s1_sd_q, s2_sd_q;
  logic signed [PT_W-1:0] p_q [3];
  logic signed [PT_W-1:0] q_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_sd_q <= '0;
      s1_sd_q <= '0;
      s2_sd_q <= '0;
    end else if (adv) begin
      s0_sd_q <= '{valid: in_valid_i, func: func_i, fault: 1'b0};
      s1_sd_q <= s0_sd_q;
      s2_sd_q <= s1_sd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= PT_W'(pos_x_i);
      p_q[1] <= PT_W'(pos_y_i);
      p_q[2] <= PT_W'(pos_z_i);
      q_q[0] <= PT_W'(pos_x_i) + PT_W'(dir_x_i);
      q_q[1] <= PT_W'(pos_y_i) + PT_W'(dir_y_i);
      q_q[2] <= PT_W'(pos_z_i) + PT_W'(dir_z_i);
    end
  end

  // matrix times point and point+dir
  logic signed [CLIP_W-1:0] clip_p [4];
  logic signed [CLIP_W-1:0] clip_q [4];

  ppts_xform u_xform_p (
    .clk_i  (clk_i),
    .en_i   (adv),
    .pt_x_i (p_q[0]),
    .pt_y_i (p_q[1]),
    .pt_z_i (p_q[2]),
    .rows_i (row_q),
    .clip_o (clip_p)
  );

  ppts_xform u_xform_q (
    .clk_i  (clk_i),
    .en_i   (adv),
    .pt_x_i (q_q[0]),
    .pt_y_i (q_q[1]),
    .pt_z_i (q_q[2]),
    .rows_i (row_q),
    .clip_o (clip_q)
  );

  // divide set-up: magnitudes, quotient sign, zero w check
  side_t            side_q [SIDE_N];
  side_t            s3_sd_d;
  logic [MAG_W-1:0] ua_q [NDIV];
  logic [MAG_W-1:0] uw_q [NDIV];
  logic             ng_q [NDIV];
  logic             wp_zero, wq_zero;

  assign wp_zero = (clip_p[3] == '0);
  assign wq_zero = (clip_q[3] == '0);

  always_comb begin
    s3_sd_d       = s2_sd_q;
    s3_sd_d.fault = (s2_sd_q.func != FUNC_NONE) &&
                    (wp_zero || ((s2_sd_q.func == FUNC_DELTA) && wq_zero));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ua_q[0] <= mag_abs(clip_p[0]);
      ua_q[1] <= mag_abs(clip_p[1]);
      ua_q[2] <= mag_abs(clip_p[2]);
      ua_q[3] <= mag_abs(clip_q[0]);
      ua_q[4] <= mag_abs(clip_q[1]);
      uw_q[0] <= mag_abs(clip_p[3]);
      uw_q[1] <= mag_abs(clip_p[3]);
      uw_q[2] <= mag_abs(clip_p[3]);
      uw_q[3] <= mag_abs(clip_q[3]);
      uw_q[4] <= mag_abs(clip_q[3]);
      ng_q[0] <= clip_p[0][CLIP_W-1] ^ clip_p[3][CLIP_W-1];
      ng_q[1] <= clip_p[1][CLIP_W-1] ^ clip_p[3][CLIP_W-1];
      ng_q[2] <= clip_p[2][CLIP_W-1] ^ clip_p[3][CLIP_W-1];
      ng_q[3] <= clip_q[0][CLIP_W-1] ^ clip_q[3][CLIP_W-1];
      ng_q[4] <= clip_q[1][CLIP_W-1] ^ clip_q[3][CLIP_W-1];
    end
  end

  // sideband travels alongside the divider and viewport stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIDE_N; i++) begin
        side_q[i] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= s3_sd_d;
      for (int i = 1; i < SIDE_N; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // five dividers: p x, y, z and pos+dir x, y
  logic [Q_W-1:0] quo [NDIV];
  logic           ovf [NDIV];
  logic           dng [NDIV];

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    ppts_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (ua_q[i]),
      .den_i (uw_q[i]),
      .neg_i (ng_q[i]),
      .quo_o (quo[i]),
      .ovf_o (ovf[i]),
      .neg_o (dng[i])
    );
  end

  // viewport mapping
  logic signed [NDC_W-1:0] ndc_px, ndc_py, ndc_qx, ndc_qy;
  logic signed [SCR_W-1:0] scr_px, scr_py, scr_qx, scr_qy;

  ppts_vport u_vport_px (
    .clk_i (clk_i), .en_i (adv), .quo_i (quo[0]), .ovf_i (ovf[0]), .neg_i (dng[0]),
    .org_i (vp_q[15:0]), .len_i (vp_q[47:32]), .ndc_o (ndc_px), .scr_o (scr_px)
  );
  ppts_vport u_vport_py (
    .clk_i (clk_i), .en_i (adv), .quo_i (quo[1]), .ovf_i (ovf[1]), .neg_i (dng[1]),
    .org_i (vp_q[31:16]), .len_i (vp_q[63:48]), .ndc_o (ndc_py), .scr_o (scr_py)
  );
  ppts_vport u_vport_qx (
    .clk_i (clk_i), .en_i (adv), .quo_i (quo[3]), .ovf_i (ovf[3]), .neg_i (dng[3]),
    .org_i (vp_q[15:0]), .len_i (vp_q[47:32]), .ndc_o (ndc_qx), .scr_o (scr_qx)
  );
  ppts_vport u_vport_qy (
    .clk_i (clk_i), .en_i (adv), .quo_i (quo[4]), .ovf_i (ovf[4]), .neg_i (dng[4]),
    .org_i (vp_q[31:16]), .len_i (vp_q[63:48]), .ndc_o (ndc_qy), .scr_o (scr_qy)
  );

  // normalised z only needs clamp and alignment
  logic signed [NDC_W-1:0] ndc_za_q, ndc_zb_q, ndc_zc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ndc_za_q <= ndc_from_quo(quo[2], ovf[2], dng[2]);
      ndc_zb_q <= ndc_za_q;
      ndc_zc_q <= ndc_zb_q;
    end
  end

  // result select and saturation
  side_t              last_sd;
  logic signed [31:0] ox_d, oy_d, oz_d;
  logic               of_d;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic               of_q;

  assign last_sd = side_q[SIDE_N-1];

  always_comb begin
    ox_d = '0;
    oy_d = '0;
    oz_d = '0;
    of_d = 1'b0;
    if (last_sd.fault) begin
      of_d = 1'b1;
    end else begin
      unique case (last_sd.func)
        FUNC_SCREEN: begin
          ox_d = sat32(scr_px);
          oy_d = sat32(scr_py);
        end
        FUNC_DELTA: begin
          ox_d = sat32(scr_qx - scr_px);
          oy_d = sat32(scr_qy - scr_py);
        end
        FUNC_NDC: begin
          ox_d = sat32(SCR_W'(ndc_px));
          oy_d = sat32(SCR_W'(ndc_py));
          oz_d = sat32(SCR_W'(ndc_zc_q));
        end
        default: ;
      endcase
    end
  end

  // pos+dir normalised values only feed the screen path
  logic unused_ndc;
  assign unused_ndc = ^{ndc_qx, ndc_qy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last_sd.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      oz_q <= oz_d;
      of_q <= of_d ^ (unused_ndc & 1'b0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign div_fault_o = of_q;

endmodule

### rtl/core/ppts_checker.sv
module ppts_checker
  import ppts_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [2:0]         cfg_idx_i,
  input logic [63:0]        cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         func_i,
  input logic signed [31:0] pos_x_i,
  input logic signed [31:0] pos_y_i,
  input logic signed [31:0] pos_z_i,
  input logic signed [31:0] dir_x_i,
  input logic signed [31:0] dir_y_i,
  input logic signed [31:0] dir_z_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_y_o,
  input logic signed [31:0] out_z_o,
  input logic               div_fault_o
);

  // input side stalls exactly when a held output beat blocks the pipeline
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output back-pressure");

  // a stalled output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) &&
      $stable(out_y_o) && $stable(out_z_o) && $stable(div_fault_o))
    else $error("stalled output beat changed");

  // a divide fault beat (zero w) carries all coordinates as zero
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_fault_o |-> (out_x_o == 0) && (out_y_o == 0) && (out_z_o == 0))
    else $error("fault beat with nonzero coordinates");

endmodule

bind perspective_project_to_screen ppts_checker u_ppts_checker (.*);
